/* rtl/ofrt_pkg.sv */
// Shared types and codes for the ordered firewall rule table.
package ofrt_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] RT_MATCH     = 3'd0;
    localparam logic [2:0] RT_INSERT    = 3'd1;
    localparam logic [2:0] RT_DELETE    = 3'd2;
    localparam logic [2:0] RT_OVERWRITE = 3'd3;
    localparam logic [2:0] RT_SWAP      = 3'd4;
    localparam logic [2:0] RT_MOVE      = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [7:0] PROTO_ANY = 8'd0;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [7:0] pos_a;
        logic signed [7:0] pos_b;
        logic [31:0]       src_addr;
        logic [31:0]       src_mask;
        logic [31:0]       dst_addr;
        logic [31:0]       dst_mask;
        logic [31:0]       src_ports;
        logic [31:0]       dst_ports;
        logic [7:0]        protocol;
        logic [7:0]        action;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       hit;
        logic [6:0] hit_position;
        logic [7:0] hit_action;
        logic [6:0] rule_count;
    } t_resp;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [31:0] src_ports;
        logic [31:0] dst_ports;
        logic [7:0]  protocol;
        logic [7:0]  action;
    } t_rule;

    // first-hit word handed down the chain during a lookup
    typedef struct packed {
        logic       found;
        logic [6:0] position;
        logic [7:0] action;
    } t_chain;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INS,
        OP_DEL,
        OP_LOAD,
        OP_SWAP
    } t_cell_op;

endpackage

/* rtl/ofrt_cell.sv */
// One rule slot: holds a rule, shifts with its neighbours, tests the lookup key.
module ofrt_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  ofrt_pkg::t_cell_op           i_op,
    input  logic [$clog2(DEPTH)-1:0]     i_lo,
    input  logic [$clog2(DEPTH)-1:0]     i_hi,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  ofrt_pkg::t_rule              i_new,
    input  ofrt_pkg::t_rule              i_key,
    input  ofrt_pkg::t_rule              i_left,
    input  ofrt_pkg::t_rule              i_right,
    output ofrt_pkg::t_rule              o_rule,
    input  ofrt_pkg::t_chain             i_chain,
    output ofrt_pkg::t_chain             o_chain
);
    import ofrt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] K = AW'(IDX);

    t_rule  r_rule;
    t_rule  n_rule;
    t_chain r_chain;
    t_chain n_chain;

    logic is_lo, next_of_lo, above_lo, upto_hi, below_hi;
    logic occupied, hit;

    assign is_lo      = (i_lo == K);
    assign next_of_lo = (IDX != 0) && (i_lo == AW'(IDX - 1));
    assign above_lo   = (K > i_lo);
    assign upto_hi    = (K <= i_hi);
    assign below_hi   = (K < i_hi);

    always_comb begin
        n_rule = r_rule;
        case (i_op)
            OP_INS: begin
                if (is_lo) begin
                    n_rule = i_new;
                end else if (above_lo && upto_hi) begin
                    n_rule = i_left;
                end
            end
            OP_DEL: begin
                if ((is_lo || above_lo) && below_hi) begin
                    n_rule = i_right;
                end
            end
            OP_LOAD: begin
                if (is_lo) begin
                    n_rule = i_new;
                end
            end
            OP_SWAP: begin
                if (is_lo) begin
                    n_rule = i_right;
                end else if (next_of_lo) begin
                    n_rule = i_left;
                end
            end
            default: n_rule = r_rule;
        endcase
    end

    assign occupied = (CW'(IDX) < i_count);
    assign hit = occupied
        && ((i_key.src_addr & r_rule.src_mask) == (r_rule.src_addr & r_rule.src_mask))
        && ((i_key.dst_addr & r_rule.dst_mask) == (r_rule.dst_addr & r_rule.dst_mask))
        && (i_key.src_ports[15:0] >= r_rule.src_ports[31:16])
        && (i_key.src_ports[15:0] <= r_rule.src_ports[15:0])
        && (i_key.dst_ports[15:0] >= r_rule.dst_ports[31:16])
        && (i_key.dst_ports[15:0] <= r_rule.dst_ports[15:0])
        && ((r_rule.protocol == PROTO_ANY) || (r_rule.protocol == i_key.protocol));

    always_comb begin
        n_chain = i_chain;
        if (!i_chain.found && hit) begin
            n_chain.found    = 1'b1;
            n_chain.position = 7'(IDX + 1);
            n_chain.action   = r_rule.action;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule  <= n_rule;
        r_chain <= n_chain;
    end

    assign o_rule  = r_rule;
    assign o_chain = r_chain;

endmodule

/* rtl/ordered_firewall_rule_table.sv */
// Flow: a lookup walks the cell chain; insert, delete and overwrite pass decode and apply;
// move and swap bubble the rule through the slots, one adjacent exchange per cycle, swap in
// two passes unless adjacent; a rejected word strobes straight from decode.
// Throughput: one word at a time; start is taken again in the cycle of the strobe.
// Lookup time is set by the first-hit word walking the cell chain one slot a cycle.
// Reset (synchronous, active low) empties the table; rule slots are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module ordered_firewall_rule_table #(
    parameter int DEPTH = ofrt_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ofrt_pkg::t_req  i_req,
    output logic            o_strobe,
    output ofrt_pkg::t_resp o_result
);
    import ofrt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APPLY,
        S_MATCH,
        S_BUBBLE
    } t_state;

    t_state          r_state;
    t_req            r_req;
    logic [CW-1:0]   r_count;
    t_cell_op        r_kind;
    logic [AW-1:0]   r_lo;
    logic [AW-1:0]   r_hi;
    logic [AW-1:0]   r_steps;
    logic            r_down;
    logic [AW-1:0]   r_p2_ptr;
    logic [AW-1:0]   r_p2_steps;
    logic [AW-1:0]   r_cnt;
    logic            r_strobe;
    t_resp           r_result;

    t_rule           w_req_rule;
    t_rule           w_rule [DEPTH];
    t_chain          w_chain [DEPTH+1];
    t_cell_op        w_op;

    function automatic logic [AW:0] f_resolve(input logic [7:0] p, input logic [CW-1:0] n);
        logic [7:0]    mag;
        logic [PW-1:0] m;
        logic [PW-1:0] nn;
        logic [PW-1:0] d;
        logic          ok;
        mag = p[7] ? (~p + 8'd1) : p;
        m   = PW'(mag);
        nn  = PW'(n);
        ok  = (m != '0) && (m <= nn);
        d   = p[7] ? (nn - m) : (m - PW'(1));
        return {ok, d[AW-1:0]};
    endfunction

    logic          w_ok_a, w_ok_b;
    logic [AW-1:0] w_idx_a, w_idx_b;
    logic [CW-1:0] w_ins_i;
    logic [AW-1:0] w_min, w_max, w_to;

    assign {w_ok_a, w_idx_a} = f_resolve(r_req.pos_a, r_count);
    assign {w_ok_b, w_idx_b} = f_resolve(r_req.pos_b, r_count);
    assign w_ins_i = (r_req.pos_a == '0) ? '0 : (CW'(w_idx_a) + CW'(1));
    assign w_min   = (w_idx_a < w_idx_b) ? w_idx_a : w_idx_b;
    assign w_max   = (w_idx_a < w_idx_b) ? w_idx_b : w_idx_a;
    // move target: after the rule named by pos_b, or the head
    assign w_to    = (r_req.pos_b == '0) ? '0 :
                     ((w_idx_b > w_idx_a) ? w_idx_b : (w_idx_b + AW'(1)));

    assign w_req_rule = '{src_addr:  r_req.src_addr,  src_mask:  r_req.src_mask,
                          dst_addr:  r_req.dst_addr,  dst_mask:  r_req.dst_mask,
                          src_ports: r_req.src_ports, dst_ports: r_req.dst_ports,
                          protocol:  r_req.protocol,  action:    r_req.action};

    always_comb begin
        w_op = OP_NONE;
        if (r_state == S_APPLY) begin
            w_op = r_kind;
        end else if (r_state == S_BUBBLE && r_steps != '0) begin
            w_op = OP_SWAP;
        end
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_rule w_left, w_right;
        if (g == 0) begin : g_l0
            assign w_left = w_rule[0];
        end else begin : g_ln
            assign w_left = w_rule[g-1];
        end
        if (g == DEPTH - 1) begin : g_rl
            assign w_right = w_rule[DEPTH-1];
        end else begin : g_rn
            assign w_right = w_rule[g+1];
        end
        ofrt_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_lo    (r_lo),
            .i_hi    (r_hi),
            .i_count (r_count),
            .i_new   (w_req_rule),
            .i_key   (w_req_rule),
            .i_left  (w_left),
            .i_right (w_right),
            .o_rule  (w_rule[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_result.hit          <= 1'b0;
                    r_result.hit_position <= '0;
                    r_result.hit_action   <= '0;
                    case (r_req.req_type)
                        RT_MATCH: begin
                            r_result.status     <= ST_OK;
                            r_result.rule_count <= 7'(r_count);
                            r_strobe            <= 1'b0;
                            r_cnt               <= '0;
                            r_state             <= S_MATCH;
                        end
                        RT_INSERT: begin
                            if (!(r_req.pos_a == '0 || w_ok_a)) begin
                                r_result.status     <= ST_BADPOS;
                                r_result.rule_count <= 7'(r_count);
                                r_strobe            <= 1'b1;
                                r_state             <= S_IDLE;
                            end else if (r_count == CW'(DEPTH)) begin
                                r_result.status     <= ST_FULL;
                                r_result.rule_count <= 7'(r_count);
                                r_strobe            <= 1'b1;
                                r_state             <= S_IDLE;
                            end else begin
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_kind  <= OP_INS;
                                r_lo    <= w_ins_i[AW-1:0];
                                r_hi    <= r_count[AW-1:0];
                                r_count <= r_count + CW'(1);
                                r_result.rule_count <= 7'(r_count + CW'(1));
                                r_state <= S_APPLY;
                            end
                        end
                        RT_DELETE: begin
                            if (!w_ok_a) begin
                                r_result.status     <= ST_BADPOS;
                                r_result.rule_count <= 7'(r_count);
                                r_strobe            <= 1'b1;
                                r_state             <= S_IDLE;
                            end else begin
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_kind  <= OP_DEL;
                                r_lo    <= w_idx_a;
                                r_hi    <= AW'(r_count - CW'(1));
                                r_count <= r_count - CW'(1);
                                r_result.rule_count <= 7'(r_count - CW'(1));
                                r_state <= S_APPLY;
                            end
                        end
                        RT_OVERWRITE: begin
                            r_result.rule_count <= 7'(r_count);
                            if (!w_ok_a) begin
                                r_result.status <= ST_BADPOS;
                                r_strobe        <= 1'b1;
                                r_state         <= S_IDLE;
                            end else begin
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_kind  <= OP_LOAD;
                                r_lo    <= w_idx_a;
                                r_state <= S_APPLY;
                            end
                        end
                        RT_SWAP: begin
                            r_result.rule_count <= 7'(r_count);
                            if (!w_ok_a || !w_ok_b) begin
                                r_result.status <= ST_BADPOS;
                                r_strobe        <= 1'b1;
                                r_state         <= S_IDLE;
                            end else begin
                                // bubble the front rule back, then the other one forward
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_lo       <= w_min;
                                r_steps    <= w_max - w_min;
                                r_down     <= 1'b0;
                                r_p2_ptr   <= w_max - AW'(1) - AW'(1);
                                r_p2_steps <= (w_max == w_min) ? '0 :
                                              (w_max - AW'(1) - w_min);
                                r_state    <= S_BUBBLE;
                            end
                        end
                        RT_MOVE: begin
                            r_result.rule_count <= 7'(r_count);
                            if (!w_ok_a || (r_req.pos_b != '0 &&
                                            (!w_ok_b || w_idx_b == w_idx_a))) begin
                                r_result.status <= ST_BADPOS;
                                r_strobe        <= 1'b1;
                                r_state         <= S_IDLE;
                            end else if (w_to >= w_idx_a) begin
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_lo       <= w_idx_a;
                                r_steps    <= w_to - w_idx_a;
                                r_down     <= 1'b0;
                                r_p2_steps <= '0;
                                r_state    <= S_BUBBLE;
                            end else begin
                                r_result.status <= ST_OK;
                                r_strobe        <= 1'b0;
                                r_lo       <= w_idx_a - AW'(1);
                                r_steps    <= w_idx_a - w_to;
                                r_down     <= 1'b1;
                                r_p2_steps <= '0;
                                r_state    <= S_BUBBLE;
                            end
                        end
                        default: begin
                            r_result.status     <= ST_BADPOS;
                            r_result.rule_count <= 7'(r_count);
                            r_strobe            <= 1'b1;
                            r_state             <= S_IDLE;
                        end
                    endcase
                end
                S_APPLY: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_MATCH: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_result.hit          <= w_chain[DEPTH].found;
                        r_result.hit_position <= w_chain[DEPTH].found ?
                                                 w_chain[DEPTH].position : 7'd0;
                        r_result.hit_action   <= w_chain[DEPTH].found ?
                                                 w_chain[DEPTH].action : 8'd0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_strobe <= 1'b0;
                    end
                end
                S_BUBBLE: begin
                    if (r_steps != '0) begin
                        r_strobe <= 1'b0;
                        r_lo    <= r_down ? (r_lo - AW'(1)) : (r_lo + AW'(1));
                        r_steps <= r_steps - AW'(1);
                    end else if (r_p2_steps != '0) begin
                        r_strobe   <= 1'b0;
                        r_lo       <= r_p2_ptr;
                        r_steps    <= r_p2_steps;
                        r_p2_steps <= '0;
                        r_down     <= 1'b1;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("rule count above table depth");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not raise busy");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result shown while still busy");
    a_edit_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> !o_result.hit)
        else $error("error result carries a hit");
`endif

endmodule

/* tb/ordered_firewall_rule_table_tb.sv */
// Self-checking testbench for the ordered firewall rule table.
module ordered_firewall_rule_table_tb;
    import ofrt_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // request codes with no defined operation
    localparam logic [2:0] RT_BAD_LO = 3'd6;
    localparam logic [2:0] RT_BAD_HI = 3'd7;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_resp o_result;

    ordered_firewall_rule_table #(.DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // shadow copy of the rule table
    t_rule rule_tbl[DEPTH];
    int    n_rules;

    t_resp pending_results[$];
    int    n_errors;
    int    n_words;
    int    n_hits;
    int    n_full;
    int    n_badpos;

    typedef struct {
        t_req  req;
        bit    typed;
        t_resp want;
    } t_row;

    function automatic bit resolve_pos(int p, int n, output int idx);
        idx = 0;
        if (p > 0 && p <= n) begin
            idx = p - 1;
            return 1'b1;
        end
        if (p < 0 && -p <= n) begin
            idx = n + p;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit port_ok(logic [31:0] range, logic [15:0] port);
        return port >= range[31:16] && port <= range[15:0];
    endfunction

    function automatic bit rule_hits(t_rule r, t_req k);
        return ((k.src_addr & r.src_mask) == (r.src_addr & r.src_mask)) &&
               ((k.dst_addr & r.dst_mask) == (r.dst_addr & r.dst_mask)) &&
               port_ok(r.src_ports, k.src_ports[15:0]) &&
               port_ok(r.dst_ports, k.dst_ports[15:0]) &&
               (r.protocol == PROTO_ANY || r.protocol == k.protocol);
    endfunction

    function automatic t_rule rule_of(t_req q);
        t_rule r;
        r.src_addr  = q.src_addr;
        r.src_mask  = q.src_mask;
        r.dst_addr  = q.dst_addr;
        r.dst_mask  = q.dst_mask;
        r.src_ports = q.src_ports;
        r.dst_ports = q.dst_ports;
        r.protocol  = q.protocol;
        r.action    = q.action;
        return r;
    endfunction

    // shift rules so the one at from lands at dest
    function automatic void relocate_rule(int from, int dest);
        t_rule t;
        t = rule_tbl[from];
        if (dest > from)
            for (int k = from; k < dest; k++) rule_tbl[k] = rule_tbl[k + 1];
        else
            for (int k = from; k > dest; k--) rule_tbl[k] = rule_tbl[k - 1];
        rule_tbl[dest] = t;
    endfunction

    // applies one request to the shadow table, returns the response word
    function automatic t_resp classify_and_edit(t_req q);
        t_resp rs;
        int    pa;
        int    pb;
        int    i;
        int    j;
        t_rule t;
        rs = '0;
        pa = q.pos_a;
        pb = q.pos_b;
        case (q.req_type)
            RT_MATCH: begin
                for (int k = 0; k < n_rules; k++)
                    if (rule_hits(rule_tbl[k], q)) begin
                        rs.hit          = 1'b1;
                        rs.hit_position = 7'(k + 1);
                        rs.hit_action   = rule_tbl[k].action;
                        break;
                    end
            end
            RT_INSERT: begin
                if (pa == 0) i = 0;
                else if (resolve_pos(pa, n_rules, j)) i = j + 1;
                else i = -1;
                if (i < 0) rs.status = ST_BADPOS;
                else if (n_rules >= DEPTH) rs.status = ST_FULL;
                else begin
                    for (int k = n_rules; k > i; k--) rule_tbl[k] = rule_tbl[k - 1];
                    rule_tbl[i] = rule_of(q);
                    n_rules++;
                end
            end
            RT_DELETE: begin
                if (!resolve_pos(pa, n_rules, i)) rs.status = ST_BADPOS;
                else begin
                    for (int k = i; k + 1 < n_rules; k++) rule_tbl[k] = rule_tbl[k + 1];
                    n_rules--;
                end
            end
            RT_OVERWRITE: begin
                if (!resolve_pos(pa, n_rules, i)) rs.status = ST_BADPOS;
                else rule_tbl[i] = rule_of(q);
            end
            RT_SWAP: begin
                if (!resolve_pos(pa, n_rules, i) || !resolve_pos(pb, n_rules, j))
                    rs.status = ST_BADPOS;
                else begin
                    t = rule_tbl[i];
                    rule_tbl[i] = rule_tbl[j];
                    rule_tbl[j] = t;
                end
            end
            RT_MOVE: begin
                if (!resolve_pos(pa, n_rules, i)) rs.status = ST_BADPOS;
                else if (pb == 0) relocate_rule(i, 0);
                else if (!resolve_pos(pb, n_rules, j) || j == i) rs.status = ST_BADPOS;
                else relocate_rule(i, j > i ? j : j + 1);
            end
            default: rs.status = ST_BADPOS;
        endcase
        rs.rule_count = 7'(n_rules);
        return rs;
    endfunction

    function automatic t_req blank_req(logic [2:0] rt, int pa, int pb);
        t_req q;
        q = '0;
        q.req_type = rt;
        q.pos_a    = 8'(pa);
        q.pos_b    = 8'(pb);
        return q;
    endfunction

    function automatic logic [31:0] prefix_mask();
        int len;
        len = $urandom_range(0, 32);
        if ($urandom_range(0, 9) == 0) return $urandom();
        return len == 0 ? 32'h0 : ~32'h0 << (32 - len);
    endfunction

    function automatic logic [31:0] port_range();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = $urandom();
        hi = $urandom();
        case ($urandom_range(0, 5))
            0: return 32'h0000_FFFF;
            1: return $urandom();
            2: return {lo, lo};
            default: return lo <= hi ? {lo, hi} : {hi, lo};
        endcase
    endfunction

    function automatic t_req rand_rule_req(logic [2:0] rt, int pa, int pb);
        t_req q;
        q = blank_req(rt, pa, pb);
        q.src_addr  = $urandom();
        q.src_mask  = prefix_mask();
        q.dst_addr  = $urandom();
        q.dst_mask  = prefix_mask();
        q.src_ports = port_range();
        q.dst_ports = port_range();
        q.protocol  = $urandom_range(0, 2) == 0 ? PROTO_ANY : 8'($urandom());
        q.action    = $urandom();
        return q;
    endfunction

    // lookup key, usually built to satisfy some held rule
    function automatic t_req rand_key();
        t_req  q;
        t_rule r;
        q = rand_rule_req(RT_MATCH, $urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64);
        if (n_rules > 0 && $urandom_range(0, 3) != 0) begin
            r = rule_tbl[$urandom_range(0, n_rules - 1)];
            q.src_addr = (r.src_addr & r.src_mask) | ($urandom() & ~r.src_mask);
            q.dst_addr = (r.dst_addr & r.dst_mask) | ($urandom() & ~r.dst_mask);
            if (r.src_ports[31:16] <= r.src_ports[15:0])
                q.src_ports[15:0] = 16'($urandom_range(r.src_ports[31:16], r.src_ports[15:0]));
            if (r.dst_ports[31:16] <= r.dst_ports[15:0])
                q.dst_ports[15:0] = 16'($urandom_range(r.dst_ports[31:16], r.dst_ports[15:0]));
            if (r.protocol != PROTO_ANY && $urandom_range(0, 4) != 0) q.protocol = r.protocol;
        end
        return q;
    endfunction

    function automatic int pick_pos(bit allow_head);
        int p;
        if (n_rules > 0 && $urandom_range(0, 7) != 0) begin
            p = $urandom_range(1, n_rules);
            return $urandom_range(0, 1) ? p : -p;
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1: return n_rules < DEPTH ? $urandom_range(n_rules + 1, 64) : 64;
            2: return n_rules < DEPTH ? -$urandom_range(n_rules + 1, 64) : -64;
            default: return allow_head ? 0 : -64;
        endcase
    endfunction

    task automatic send_word(t_req q, int gap, bit typed, t_resp want);
        t_resp rs;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        rs = classify_and_edit(q);
        if (typed) rs = want;
        pending_results.push_back(rs);
        n_words++;
    endtask

    function automatic int draw_gap(int idx);
        if (idx % 100 < 30) return 0;
        return $urandom_range(0, 8);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                n_errors++;
            end else begin
                if (o_result !== pending_results[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             pending_results[0], o_result);
                    n_errors++;
                end
                if (o_result.hit === 1'b1) n_hits++;
                if (o_result.status === ST_FULL) n_full++;
                if (o_result.status === ST_BADPOS) n_badpos++;
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_row  row;
        t_req  q;
        t_resp none;
        int    op;
        none      = '0;
        n_rules   = 0;
        n_errors  = 0;
        n_words   = 0;
        n_hits    = 0;
        n_full    = 0;
        n_badpos  = 0;
        start     = 1'b0;
        i_req     = '0;
        i_rst_n   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: typed answers only where they are obvious
        row.typed = 1'b1; row.want = none;
        row.req = blank_req(RT_MATCH, 0, 0); rows.push_back(row);
        row.want.status = ST_BADPOS;
        row.req = blank_req(RT_DELETE, 1, 0); rows.push_back(row);
        row.req = blank_req(RT_INSERT, 5, 0); rows.push_back(row);
        row.want = none; row.want.rule_count = 7'd1;
        row.req = blank_req(RT_INSERT, 0, 0);
        row.req.src_ports = 32'h0000_FFFF; row.req.dst_ports = 32'h0000_FFFF;
        row.req.action = 8'hFF; rows.push_back(row);
        row.want.rule_count = 7'd2;
        row.req = blank_req(RT_INSERT, -1, 0);
        row.req.src_addr = 32'hFFFF_FFFF; row.req.src_mask = 32'hFFFF_FFFF;
        row.req.dst_addr = 32'hFFFF_FFFF; row.req.dst_mask = 32'hFFFF_FFFF;
        row.req.src_ports = 32'hFFFF_FFFF; row.req.dst_ports = 32'hFFFF_FFFF;
        row.req.protocol = 8'hFF; row.req.action = 8'h5A; rows.push_back(row);
        row.want.rule_count = 7'd3;
        row.req = blank_req(RT_INSERT, 1, 0);
        row.req.src_ports = 32'h0050_0050; row.req.dst_ports = 32'h0000_0400;
        row.req.protocol = 8'd6; row.req.action = 8'h01; rows.push_back(row);
        row.typed = 1'b0;
        row.req = blank_req(RT_MATCH, 0, 0);
        row.req.src_ports = 32'h50; row.req.protocol = 8'd6; rows.push_back(row);
        row.req = blank_req(RT_MATCH, -64, 64);
        row.req.src_addr = '1; row.req.src_mask = '1; row.req.dst_addr = '1;
        row.req.dst_mask = '1; row.req.src_ports = '1; row.req.dst_ports = '1;
        row.req.protocol = '1; row.req.action = '1; rows.push_back(row);
        row.req = rand_rule_req(RT_OVERWRITE, -3, 0); rows.push_back(row);
        row.req = blank_req(RT_SWAP, 1, -1); rows.push_back(row);
        row.req = blank_req(RT_SWAP, 2, -2); rows.push_back(row);   // rule with itself
        row.typed = 1'b1; row.want = none;
        row.want.status = ST_BADPOS; row.want.rule_count = 7'd3;
        row.req = blank_req(RT_MOVE, 1, 1); rows.push_back(row);    // after itself
        row.req = blank_req(RT_BAD_LO, 1, 1); rows.push_back(row);
        row.req = blank_req(RT_BAD_HI, -1, -1); rows.push_back(row);
        row.req = blank_req(RT_DELETE, 0, 0); rows.push_back(row);
        row.req = blank_req(RT_DELETE, -4, 0); rows.push_back(row);
        row.req = blank_req(RT_OVERWRITE, 64, 0); rows.push_back(row);
        row.req = blank_req(RT_SWAP, 1, 64); rows.push_back(row);
        row.typed = 1'b0;
        row.req = blank_req(RT_MOVE, -1, 0); rows.push_back(row);
        row.req = blank_req(RT_MOVE, 2, 1); rows.push_back(row);    // already in place
        row.req = blank_req(RT_MOVE, 1, 3); rows.push_back(row);
        row.req = blank_req(RT_MOVE, 3, -3); rows.push_back(row);
        row.req = blank_req(RT_MATCH, 0, 0); rows.push_back(row);
        row.req = blank_req(RT_DELETE, -1, 0); rows.push_back(row);

        foreach (rows[k]) send_word(rows[k].req, $urandom_range(0, 8), rows[k].typed,
                                     rows[k].want);

        for (int k = 0; k < 800; k++) begin
            if (k == 250) begin
                // fill to the brim, then poke the full table
                while (n_rules < DEPTH)
                    send_word(rand_rule_req(RT_INSERT, pick_pos(1'b1), 0),
                              $urandom_range(0, 2), 1'b0, none);
                send_word(rand_rule_req(RT_INSERT, 0, 0), 0, 1'b0, none);
                send_word(rand_rule_req(RT_INSERT, -64, 0), 1, 1'b0, none);
                send_word(rand_rule_req(RT_INSERT, 0, 0), 0, 1'b0, none);
                for (int m = 0; m < 20; m++)
                    send_word(rand_key(), draw_gap(m), 1'b0, none);
                send_word(blank_req(RT_MOVE, 1, -1), 0, 1'b0, none);
                send_word(blank_req(RT_SWAP, 64, -64), 0, 1'b0, none);
                start <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end
            if (k == 600)
                while (n_rules > 0)
                    send_word(blank_req(RT_DELETE, pick_pos(1'b0), 0), draw_gap(k),
                              1'b0, none);
            op = $urandom_range(0, 99);
            if (op < 40) q = rand_key();
            else if (op < 62) q = rand_rule_req(RT_INSERT, pick_pos(1'b1), 0);
            else if (op < 74) q = blank_req(RT_DELETE, pick_pos(1'b0), 0);
            else if (op < 82) q = rand_rule_req(RT_OVERWRITE, pick_pos(1'b0), 0);
            else if (op < 90) q = blank_req(RT_SWAP, pick_pos(1'b0), pick_pos(1'b0));
            else if (op < 98) q = blank_req(RT_MOVE, pick_pos(1'b0), pick_pos(1'b1));
            else q = rand_rule_req($urandom_range(0, 1) ? RT_BAD_LO : RT_BAD_HI,
                                   pick_pos(1'b1), pick_pos(1'b1));
            send_word(q, draw_gap(k), 1'b0, none);
        end
        start <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (2 * DEPTH + 10) @(posedge i_clk);
        $display("Sent %0d words: lookups with %0d hits, %0d full-table and %0d bad-position",
                 n_words, n_hits, n_full, n_badpos);
        $display("responses, table filled to %0d rules and drained again.", DEPTH);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
